[rtl/core/acd_pkg.sv]
// Shared types and constants for the asymmetric clip distortion block.
// No dependencies.
`default_nettype none

package acd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 25;
  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 16;
  localparam int CLIP_W   = 23;
  localparam int LEVEL_W  = 31;
  localparam int DATA_W   = 31;
  localparam int INDEX_W  = 3;
  localparam int PROD_W   = 40;
  localparam int GAINED_W = 32;
  localparam int QUOT_W   = 32;
  localparam int ROOT_W   = 17;

  localparam int DIV_BITS_PER_STAGE  = 2;
  localparam int DIV_STAGES          = QUOT_W / DIV_BITS_PER_STAGE;
  localparam int SQRT_BITS_PER_STAGE = 2;
  localparam int SQRT_STAGES         = (QUOT_W / 2) / SQRT_BITS_PER_STAGE;

  localparam logic [MODE_W-1:0] MODE_HARD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOFT = 2'd2;

  localparam logic [INDEX_W-1:0] REG_MODE_POS = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MODE_NEG = 3'd1;
  localparam logic [INDEX_W-1:0] REG_GAIN_POS = 3'd2;
  localparam logic [INDEX_W-1:0] REG_GAIN_NEG = 3'd3;
  localparam logic [INDEX_W-1:0] REG_CLIP_POS = 3'd4;
  localparam logic [INDEX_W-1:0] REG_CLIP_NEG = 3'd5;
  localparam logic [INDEX_W-1:0] REG_MAX_LVL  = 3'd6;

  localparam logic [ROOT_W-1:0] ROOT_ONE = 17'h10000;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              use_s;
    logic              sat;
    logic [CLIP_W-1:0] clip;
    logic [23:0]       fixed;
  } ctl_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [LEVEL_W-1:0] rem;
    logic [LEVEL_W-1:0] den;
    logic [QUOT_W-1:0]  q;
  } div_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [QUOT_W-1:0] v;
    logic [QUOT_W-1:0] res;
  } sqrt_t;

endpackage

`default_nettype wire

[rtl/core/asymmetric_clip_distortion_top.sv]
// Asymmetric clip distortion: gain, clip or soft curve per sign of the sample.
// Depends on acd_pkg for widths, codes and pipeline record types.
//
// Usage:
//   Input: drive sample_in with start high; the word is taken at a clock edge
//   where start is high and busy is low. busy is low except during reset, so a
//   new word may be offered in every cycle.
//   Output: done is high for one cycle with sample_out valid; the receiver
//   takes it in that cycle and cannot hold it off.
//   Configuration: wr_en, wr_index and wr_data write one register per edge;
//   write only while no word is in flight.
// Throughput: one word per cycle; set by the pipelined datapath of one
//   multiply stage, a 16-stage restoring divider (2 quotient bits per stage),
//   an 8-stage digit-by-digit square root (2 root bits per stage), a scaling
//   multiply stage and an output stage.
// Reset: synchronous; clears the registers to their defaults and drops every
//   word in flight.
`default_nettype none

module asymmetric_clip_distortion_top
  import acd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  output logic                           done,
  output logic signed [OUT_W-1:0]        sample_out,
  input  wire logic                      wr_en,
  input  wire logic [INDEX_W-1:0]        wr_index,
  input  wire logic [DATA_W-1:0]         wr_data
);

  logic [MODE_W-1:0]  mode_pos;
  logic [MODE_W-1:0]  mode_neg;
  logic [GAIN_W-1:0]  pos_gain;
  logic [GAIN_W-1:0]  neg_gain;
  logic [CLIP_W-1:0]  pos_clip;
  logic [CLIP_W-1:0]  neg_clip;
  logic [LEVEL_W-1:0] max_level;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_pos  <= '0;
      mode_neg  <= '0;
      pos_gain  <= GAIN_W'(256);
      neg_gain  <= GAIN_W'(256);
      pos_clip  <= '1;
      neg_clip  <= '1;
      max_level <= LEVEL_W'(838860800);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE_POS: mode_pos  <= wr_data[MODE_W-1:0];
        REG_MODE_NEG: mode_neg  <= wr_data[MODE_W-1:0];
        REG_GAIN_POS: pos_gain  <= wr_data[GAIN_W-1:0];
        REG_GAIN_NEG: neg_gain  <= wr_data[GAIN_W-1:0];
        REG_CLIP_POS: pos_clip  <= wr_data[CLIP_W-1:0];
        REG_CLIP_NEG: neg_clip  <= wr_data[CLIP_W-1:0];
        REG_MAX_LVL:  max_level <= wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_raw <= sample_in;
  end

  // gain stage
  logic                positive;
  logic [SAMPLE_W-1:0] mag;
  logic [GAIN_W-1:0]   gain_sel;
  logic [PROD_W-1:0]   gain_prod;

  logic                g_valid;
  logic                g_neg;
  logic [MODE_W-1:0]   g_mode;
  logic [CLIP_W-1:0]   g_clip;
  logic [SAMPLE_W-1:0] g_mag;
  logic [GAINED_W-1:0] g_val;

  always_comb begin
    positive  = !in_raw[SAMPLE_W-1] && (in_raw != '0);
    mag       = in_raw[SAMPLE_W-1] ? (~in_raw + SAMPLE_W'(1)) : in_raw;
    gain_sel  = positive ? pos_gain : neg_gain;
    gain_prod = PROD_W'(mag) * PROD_W'(gain_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= in_valid;
    end
    g_neg  <= !positive;
    g_mode <= positive ? mode_pos : mode_neg;
    g_clip <= positive ? pos_clip : neg_clip;
    g_mag  <= mag;
    g_val  <= gain_prod[PROD_W-1:8];
  end

  // classify stage
  logic                  shaping;
  logic                  below;
  logic [GAINED_W:0]     den_w;
  logic [GAINED_W-1:0]   num;
  logic                  den_pos;
  div_t                  div_head;

  always_comb begin
    shaping = (g_mode == MODE_HARD) || (g_mode == MODE_SOFT);
    below   = g_val <= GAINED_W'(g_clip);
    num     = g_val - GAINED_W'(g_clip);
    den_w   = (GAINED_W + 1)'(max_level) - (GAINED_W + 1)'(g_clip);
    den_pos = !den_w[GAINED_W] && (den_w != '0);

    div_head           = '0;
    div_head.ctl.valid = g_valid;
    div_head.ctl.neg   = g_neg;
    div_head.ctl.clip  = g_clip;
    div_head.ctl.use_s = shaping && !below && (g_mode == MODE_SOFT);
    div_head.ctl.sat   = !den_pos || ({1'b0, num} >= den_w);
    if (!shaping) begin
      div_head.ctl.fixed = g_mag;
    end else if (below) begin
      div_head.ctl.fixed = g_val[SAMPLE_W-1:0];
    end else begin
      div_head.ctl.fixed = SAMPLE_W'(g_clip);
    end
    div_head.rem = num[LEVEL_W-1:0];
    div_head.den = den_w[LEVEL_W-1:0];
    div_head.q   = '0;
  end

  // restoring divider
  div_t div_q [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_q[0].ctl.valid <= 1'b0;
    end else begin
      div_q[0] <= div_head;
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    div_t div_next;

    always_comb begin
      logic [LEVEL_W:0] r2;
      div_next = div_q[i];
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        r2 = {div_next.rem, 1'b0};
        if (r2 >= {1'b0, div_next.den}) begin
          div_next.rem = LEVEL_W'(r2 - {1'b0, div_next.den});
          div_next.q   = {div_next.q[QUOT_W-2:0], 1'b1};
        end else begin
          div_next.rem = r2[LEVEL_W-1:0];
          div_next.q   = {div_next.q[QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_q[i+1].ctl.valid <= 1'b0;
      end else begin
        div_q[i+1] <= div_next;
      end
    end
  end

  // digit-by-digit square root
  sqrt_t sqrt_head;
  sqrt_t sqrt_q [SQRT_STAGES];

  always_comb begin
    sqrt_head.ctl = div_q[DIV_STAGES].ctl;
    sqrt_head.v   = div_q[DIV_STAGES].q;
    sqrt_head.res = '0;
  end

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    sqrt_t sqrt_in;
    sqrt_t sqrt_next;

    if (j == 0) begin : g_first
      assign sqrt_in = sqrt_head;
    end else begin : g_rest
      assign sqrt_in = sqrt_q[j-1];
    end

    always_comb begin
      logic [QUOT_W:0] bit_w;
      logic [QUOT_W:0] sum;
      sqrt_next = sqrt_in;
      for (int k = 0; k < SQRT_BITS_PER_STAGE; k++) begin
        bit_w = (QUOT_W + 1)'(1) << (QUOT_W - 2 - 2 * (j * SQRT_BITS_PER_STAGE + k));
        sum   = {1'b0, sqrt_next.res} + bit_w;
        if ({1'b0, sqrt_next.v} >= sum) begin
          sqrt_next.v   = QUOT_W'({1'b0, sqrt_next.v} - sum);
          sqrt_next.res = (sqrt_next.res >> 1) + bit_w[QUOT_W-1:0];
        end else begin
          sqrt_next.res = sqrt_next.res >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sqrt_q[j].ctl.valid <= 1'b0;
      end else begin
        sqrt_q[j] <= sqrt_next;
      end
    end
  end

  // scale stage
  logic [ROOT_W-1:0] root;
  ctl_t              m_ctl;
  logic [PROD_W-1:0] m_prod;

  assign root = sqrt_q[SQRT_STAGES-1].ctl.sat ? ROOT_ONE
                                              : sqrt_q[SQRT_STAGES-1].res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_ctl.valid <= 1'b0;
    end else begin
      m_ctl <= sqrt_q[SQRT_STAGES-1].ctl;
    end
    m_prod <= PROD_W'(sqrt_q[SQRT_STAGES-1].ctl.clip) * PROD_W'(root);
  end

  // output stage
  logic [SAMPLE_W-1:0] res_mag;
  logic [OUT_W-1:0]    res_out;

  always_comb begin
    res_mag = m_ctl.use_s ? (SAMPLE_W'(m_ctl.clip) + SAMPLE_W'(m_prod[PROD_W-1:17]))
                          : m_ctl.fixed;
    res_out = m_ctl.neg ? (OUT_W'(0) - OUT_W'(res_mag)) : OUT_W'(res_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_ctl.valid;
    end
    sample_out <= res_out;
  end

endmodule

`default_nettype wire
